[rtl/assert_macros.svh]
// assertion macros used by the descrambler datapath
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/kud_pkg.sv]
// shared constants, codes, control structs and key helper for the descrambler
// no dependencies
package kud_pkg;

    localparam int MAX_BYTES_DEF = 4096;
    localparam int KEY_BYTES     = 16;
    localparam int LCG_W         = 31;

    localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
    localparam logic [31:0] FNV_PRIME = 32'h01000193;
    localparam logic [31:0] LCG_MUL   = 32'd1103515245;
    localparam logic [31:0] LCG_INC   = 32'd12345;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [1:0] {
        CFG_KEY_LOW   = 2'd0,
        CFG_KEY_HIGH  = 2'd1,
        CFG_SHUF_EN   = 2'd2,
        CFG_XOR_EN    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic load;
        logic rd_issue;
        logic out_load;
        logic seed_init;
        logic seed_step;
        logic lcg_init;
        logic lcg_step;
        logic div_start;
        logic swap_wr;
        logic walk_init;
        logic sw_rd_idx;
        logic sw_rd_bytes;
        logic sw_wr_i;
        logic sw_wr_j;
        logic xor_init;
        logic xr_rd;
        logic xr_wr;
        logic set_done;
    } kud_cmd_t;

    typedef struct packed {
        logic len_gt1;
        logic seed_last;
        logic div_done;
        logic i_one;
        logic walk_last;
        logic out_free;
        logic shuffle_en;
        logic xor_en;
    } kud_stat_t;

    function automatic logic [7:0] key_byte(input logic [63:0] lo, input logic [63:0] hi,
                                            input logic [3:0] k);
        logic [127:0] key;
        key = {hi, lo};
        return key[{k, 3'b000} +: 8];
    endfunction

endpackage

[rtl/keyed_unshuffle_xor_descrambler_top.sv]
// top level: stream ports, configuration registers, controller and datapath
// uses kud_pkg, kud_ctrl, kud_dp
// a load word is written to the byte store as it is taken; a read word passes S_RD and S_OUT
// before its result is registered onto m_, and the next word is taken after that, later while
// an earlier result waits for m_tready; the final load word starts the finish: seed setup, then
// per position above zero index generation by the 31-step remainder unit and a swap walk, then
// the xor pass over the bytes; no word and no register write is taken until it is over
// reset: aresetn synchronous active low; byte and index memories are left undefined
module keyed_unshuffle_xor_descrambler_top #(
    parameter int MAX_BYTES = kud_pkg::MAX_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // data_byte[7:0], read_index[19:8], zero[23:20]
    input  logic        s_tuser,  // op
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // out_byte[7:0], index_valid[8], overflow_flag[9], zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import kud_pkg::*;

    logic [63:0] key_low_reg, key_high_reg;
    logic        shuf_en_reg, xor_en_reg;
    kud_cmd_t    cmd;
    kud_stat_t   stat;
    logic [7:0]  out_byte;
    logic        index_valid, overflow_flag;

    // registers only change while the controller is idle
    assign cfg_ready = s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= 64'd6868074465101826641;
            key_high_reg <= 64'd3761121631713969483;
            shuf_en_reg  <= 1'b1;
            xor_en_reg   <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                CFG_SHUF_EN:  shuf_en_reg  <= cfg_data[0];
                CFG_XOR_EN:   xor_en_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    kud_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .op       (s_tuser),
        .last     (s_tlast),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    kud_dp #(.MAX_BYTES(MAX_BYTES)) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .data_byte     (s_tdata[7:0]),
        .read_index    (s_tdata[19:8]),
        .key_low       (key_low_reg),
        .key_high      (key_high_reg),
        .shuffle_en    (shuf_en_reg),
        .xor_en        (xor_en_reg),
        .m_tready      (m_tready),
        .stat          (stat),
        .m_tvalid      (m_tvalid),
        .out_byte      (out_byte),
        .index_valid   (index_valid),
        .overflow_flag (overflow_flag)
    );

    assign m_tdata = {6'd0, overflow_flag, index_valid, out_byte};

endmodule

[rtl/kud_div.sv]
// remainder unit: 31-bit dividend by a length-wide divisor, one bit a cycle
// uses kud_pkg
module kud_div #(
    parameter int LW = 13
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [kud_pkg::LCG_W-1:0] dividend,
    input  logic [LW-1:0]         divisor,
    output logic                  done,
    output logic [LW-1:0]         rem
);
    import kud_pkg::*;

    logic [LW-1:0]    rem_reg, rem_next;
    logic [LCG_W-1:0] num_reg, num_next;
    logic [LW-1:0]    den_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg, done_reg;
    logic [LW:0]      trial;

    always_comb begin
        trial = {rem_reg, num_reg[LCG_W-1]};
        if (trial >= {1'b0, den_reg}) begin
            rem_next = LW'(trial - {1'b0, den_reg});
        end else begin
            rem_next = trial[LW-1:0];
        end
        num_next = {num_reg[LCG_W-2:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(LCG_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            num_reg <= dividend;
            den_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            num_reg <= num_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

[rtl/kud_ctrl.sv]
// sequencer for load, read, seed hash, index generation, swap walk and xor pass
// uses kud_pkg
module kud_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               op,
    input  logic               last,
    input  kud_pkg::kud_stat_t stat,
    output logic               s_tready,
    output kud_pkg::kud_cmd_t  cmd
);
    import kud_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_RD   = 13'b0000000000010,
        S_OUT  = 13'b0000000000100,
        S_FIN  = 13'b0000000001000,
        S_SEED = 13'b0000000010000,
        S_LINI = 13'b0000000100000,
        S_LCG  = 13'b0000001000000,
        S_DIVS = 13'b0000010000000,
        S_DIVW = 13'b0000100000000,
        S_SWA  = 13'b0001000000000,
        S_SWB  = 13'b0010000000000,
        S_SWC  = 13'b0100000000000,
        S_SWD  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   xr_phase_reg, xr_phase_next;

    always_comb begin
        state_next    = state_reg;
        xr_phase_next = xr_phase_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (op == OP_READ) begin
                        cmd.rd_issue = 1'b1;
                        state_next   = S_RD;
                    end else begin
                        cmd.load = 1'b1;
                        if (last) begin
                            state_next = S_FIN;
                        end
                    end
                end
            end
            S_RD: state_next = S_OUT;
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_FIN: begin
                if (stat.shuffle_en && stat.len_gt1) begin
                    cmd.seed_init = 1'b1;
                    state_next    = S_SEED;
                end else if (stat.xor_en) begin
                    cmd.xor_init  = 1'b1;
                    xr_phase_next = 1'b1;
                    state_next    = S_SWB;
                end else begin
                    cmd.set_done = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SEED: begin
                cmd.seed_step = 1'b1;
                if (stat.seed_last) begin
                    state_next = S_LINI;
                end
            end
            S_LINI: begin
                cmd.lcg_init = 1'b1;
                state_next   = S_LCG;
            end
            S_LCG: begin
                cmd.lcg_step = 1'b1;
                state_next   = S_DIVS;
            end
            S_DIVS: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVW;
            end
            S_DIVW: begin
                if (stat.div_done) begin
                    cmd.swap_wr = 1'b1;
                    if (stat.i_one) begin
                        cmd.walk_init = 1'b1;
                        xr_phase_next = 1'b0;
                        state_next    = S_SWA;
                    end else begin
                        state_next = S_LCG;
                    end
                end
            end
            S_SWA: begin
                cmd.sw_rd_idx = 1'b1;
                state_next    = S_SWB;
            end
            // xor pass reuses the read and write-back steps of the walk
            S_SWB: begin
                if (xr_phase_reg) begin
                    cmd.xr_rd = 1'b1;
                    state_next = S_SWD;
                end else begin
                    cmd.sw_rd_bytes = 1'b1;
                    state_next      = S_SWC;
                end
            end
            S_SWC: begin
                cmd.sw_wr_i = 1'b1;
                state_next  = S_SWD;
            end
            S_SWD: begin
                if (xr_phase_reg) begin
                    cmd.xr_wr = 1'b1;
                    if (stat.walk_last) begin
                        cmd.set_done = 1'b1;
                        state_next   = S_IDLE;
                    end else begin
                        state_next = S_SWB;
                    end
                end else begin
                    cmd.sw_wr_j = 1'b1;
                    if (!stat.walk_last) begin
                        state_next = S_SWA;
                    end else if (stat.xor_en) begin
                        cmd.xor_init  = 1'b1;
                        xr_phase_next = 1'b1;
                        state_next    = S_SWB;
                    end else begin
                        cmd.set_done = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            xr_phase_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            xr_phase_reg <= xr_phase_next;
        end
    end

endmodule

[rtl/kud_dp.sv]
// datapath: byte and swap-index memories, length, seed hash, lcg, walk counter,
// result register; uses kud_pkg, kud_div and assert_macros.svh
`include "assert_macros.svh"
module kud_dp #(
    parameter int MAX_BYTES = kud_pkg::MAX_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  kud_pkg::kud_cmd_t cmd,
    input  logic [7:0]        data_byte,
    input  logic [11:0]       read_index,
    input  logic [63:0]       key_low,
    input  logic [63:0]       key_high,
    input  logic              shuffle_en,
    input  logic              xor_en,
    input  logic              m_tready,
    output kud_pkg::kud_stat_t stat,
    output logic              m_tvalid,
    output logic [7:0]        out_byte,
    output logic              index_valid,
    output logic              overflow_flag
);
    import kud_pkg::*;

    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int LW = $clog2(MAX_BYTES + 1);
    localparam int CW = (LW > 12) ? LW : 12;

    logic [7:0]    byte_mem [MAX_BYTES];
    logic [AW-1:0] swap_mem [MAX_BYTES];

    logic [LW-1:0]    len_reg;
    logic             ovf_reg, done_reg;
    logic [31:0]      seed_reg;
    logic [3:0]       k_reg;
    logic [LCG_W-1:0] lcg_reg;
    logic [AW-1:0]    i_reg;
    logic [AW-1:0]    j_reg;
    logic [7:0]       rda_reg, rdb_reg;
    logic             ok_reg;
    logic             mv_reg;
    logic [7:0]       ob_reg;
    logic             iv_reg, of_reg;

    logic [LW-1:0]    base_len;
    logic [CW-1:0]    idx_w;
    logic [AW-1:0]    len_m1;
    logic [31:0]      lcg_prod, seed_prod;
    logic [15:0]      i16;
    logic             we;
    logic [AW-1:0]    wa, ra;
    logic [7:0]       wd;
    logic             div_done;
    logic [LW-1:0]    div_rem;

    assign base_len  = done_reg ? '0 : len_reg;
    assign idx_w     = CW'(read_index);
    assign len_m1    = AW'(len_reg - LW'(1));
    assign i16       = 16'(i_reg);
    assign lcg_prod  = 32'(lcg_reg) * LCG_MUL + LCG_INC;
    assign seed_prod = (seed_reg ^ 32'(key_byte(key_low, key_high, k_reg))) * FNV_PRIME;

    kud_div #(.LW(LW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (lcg_reg),
        .divisor  (LW'(i_reg) + LW'(1)),
        .done     (div_done),
        .rem      (div_rem)
    );

    always_comb begin
        we = 1'b0;
        wa = i_reg;
        wd = rdb_reg;
        ra = i_reg;
        if (cmd.load) begin
            we = (base_len < LW'(MAX_BYTES));
            wa = AW'(base_len);
            wd = data_byte;
        end else if (cmd.sw_wr_i) begin
            we = 1'b1;
        end else if (cmd.sw_wr_j) begin
            we = 1'b1;
            wa = j_reg;
            wd = rda_reg;
        end else if (cmd.xr_wr) begin
            we = 1'b1;
            wd = rda_reg ^ key_byte(key_low, key_high, i_reg[3:0]) ^ i16[7:0] ^ i16[15:8];
        end
        if (cmd.rd_issue) begin
            ra = idx_w[AW-1:0];
        end
    end

    // byte store: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (we) begin
            byte_mem[wa] <= wd;
        end
        if (cmd.rd_issue || cmd.sw_rd_bytes || cmd.xr_rd) begin
            rda_reg <= byte_mem[ra];
        end
        if (cmd.sw_rd_bytes) begin
            rdb_reg <= byte_mem[j_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.swap_wr) begin
            swap_mem[i_reg] <= div_rem[AW-1:0];
        end
        if (cmd.sw_rd_idx) begin
            j_reg <= swap_mem[i_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= '0;
            ovf_reg  <= 1'b0;
            done_reg <= 1'b0;
            mv_reg   <= 1'b0;
        end else begin
            if (cmd.load) begin
                done_reg <= 1'b0;
                if (base_len < LW'(MAX_BYTES)) begin
                    len_reg <= base_len + LW'(1);
                    ovf_reg <= done_reg ? 1'b0 : ovf_reg;
                end else begin
                    len_reg <= base_len;
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.set_done) begin
                done_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.seed_init) begin
            seed_reg <= FNV_BASIS;
            k_reg    <= '0;
        end else if (cmd.seed_step) begin
            seed_reg <= seed_prod;
            k_reg    <= k_reg + 4'd1;
        end
        if (cmd.lcg_init) begin
            lcg_reg <= seed_reg[LCG_W-1:0];
        end else if (cmd.lcg_step) begin
            lcg_reg <= lcg_prod[LCG_W-1:0];
        end
        if (cmd.lcg_init) begin
            i_reg <= len_m1;
        end else if (cmd.walk_init) begin
            i_reg <= AW'(1);
        end else if (cmd.xor_init) begin
            i_reg <= '0;
        end else if (cmd.swap_wr) begin
            i_reg <= i_reg - AW'(1);
        end else if (cmd.sw_wr_j || cmd.xr_wr) begin
            i_reg <= i_reg + AW'(1);
        end
        if (cmd.rd_issue) begin
            ok_reg <= done_reg && (idx_w < CW'(len_reg));
        end
        if (cmd.out_load) begin
            ob_reg <= ok_reg ? rda_reg : 8'd0;
            iv_reg <= ok_reg;
            of_reg <= ovf_reg;
        end
    end

    always_comb begin
        stat            = '0;
        stat.len_gt1    = (len_reg > LW'(1));
        stat.seed_last  = (k_reg == 4'(KEY_BYTES - 1));
        stat.div_done   = div_done;
        stat.i_one      = (i_reg == AW'(1));
        stat.walk_last  = (i_reg == len_m1);
        stat.out_free   = !mv_reg || m_tready;
        stat.shuffle_en = shuffle_en;
        stat.xor_en     = xor_en;
    end

    assign m_tvalid      = mv_reg;
    assign out_byte      = ob_reg;
    assign index_valid   = iv_reg;
    assign overflow_flag = of_reg;

    `ASSERT_ALWAYS(a_len_bound, aclk, aresetn, len_reg <= LW'(MAX_BYTES), "length past capacity")
    `ASSERT_IMPL(a_rem_bound, aclk, aresetn, cmd.swap_wr, div_rem <= LW'(i_reg), "swap index too big")
    `ASSERT_IMPL(a_j_bound, aclk, aresetn, cmd.sw_rd_bytes, j_reg <= i_reg, "swap partner above walk")
endmodule

[dv/keyed_unshuffle_xor_descrambler_top_tb.sv]
// testbench for the keyed unshuffle and xor descrambler: drives register writes, load and read words
// with random gaps and checks each read result against an in-bench model of the block
// depends on kud_pkg and keyed_unshuffle_xor_descrambler_top
`timescale 1ns / 100ps

module keyed_unshuffle_xor_descrambler_top_tb;
    import kud_pkg::*;

    localparam int DEPTH = 4096;

    typedef struct {
        logic [7:0] out_byte;
        logic       index_valid;
        logic       overflow_flag;
    } rd_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // data_byte[7:0], read_index[19:8], zero[23:20]
    logic        s_tuser;   // op
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;   // out_byte[7:0], index_valid[8], overflow_flag[9], zero
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    // model of the block
    logic [63:0] key_lo_m, key_hi_m;
    logic        shuf_en_m, xor_en_m;
    logic [7:0]  blob_mem [DEPTH];
    int          blob_len;
    bit          blob_done;
    bit          ovf_seen;

    rd_result_t  pending_reads [$];
    int          mismatches;
    int          words_sent;
    bit          no_idle;
    int          hold = 0;
    int          rr;

    keyed_unshuffle_xor_descrambler_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    initial begin
        #20_000_000;
        $display("keyed_unshuffle_xor_descrambler_top: mismatch");
        $finish;
    end

    function automatic logic [7:0] model_key(int k);
        logic [127:0] key;
        key = {key_hi_m, key_lo_m};
        return key[(k % 16) * 8 +: 8];
    endfunction

    // unshuffle then xor, as done when the final byte arrives
    function automatic void descramble_blob();
        logic [31:0] h;
        logic [31:0] lcg;
        logic [7:0]  t;
        int          swap_to [DEPTH];
        int          j;
        if (shuf_en_m && blob_len > 1) begin
            h = 32'h811C9DC5;
            for (int k = 0; k < 16; k++) begin
                h = (h ^ model_key(k)) * 32'h01000193;
            end
            lcg = h;
            for (int i = blob_len - 1; i > 0; i--) begin
                lcg = (lcg * 32'd1103515245 + 32'd12345) & 32'h7FFFFFFF;
                swap_to[i] = lcg % (i + 1);
            end
            for (int i = 1; i < blob_len; i++) begin
                j = swap_to[i];
                t = blob_mem[i];
                blob_mem[i] = blob_mem[j];
                blob_mem[j] = t;
            end
        end
        if (xor_en_m) begin
            for (int i = 0; i < blob_len; i++) begin
                blob_mem[i] ^= model_key(i) ^ i[7:0] ^ i[15:8];
            end
        end
        blob_done = 1'b1;
    endfunction

    function automatic void model_word(logic op, logic [7:0] d, logic last, logic [11:0] idx);
        rd_result_t r;
        bit ok;
        if (op == OP_LOAD) begin
            if (blob_done) begin
                blob_done = 1'b0;
                blob_len  = 0;
                ovf_seen  = 1'b0;
            end
            if (blob_len < DEPTH) begin
                blob_mem[blob_len] = d;
                blob_len++;
            end else begin
                ovf_seen = 1'b1;
            end
            if (last) descramble_blob();
        end else begin
            ok = blob_done && (idx < blob_len);
            r.out_byte      = ok ? blob_mem[idx] : 8'h00;
            r.index_valid   = ok;
            r.overflow_flag = ovf_seen;
            pending_reads.push_back(r);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic send_word(logic op, logic [7:0] d, logic last, logic [11:0] idx);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= last;
        s_tdata  <= {4'b0000, idx, d};
        do @(posedge aclk); while (!s_tready);
        model_word(op, d, last, idx);
        words_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic load_byte(logic [7:0] d, logic last);
        send_word(OP_LOAD, d, last, 12'($urandom));
    endtask

    task automatic read_byte(logic [11:0] idx);
        send_word(OP_READ, 8'($urandom), 1'b0, idx);
    endtask

    // block may still be descrambling after the last result, so allow its finish time
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge aclk);
        repeat (100 + 45 * blob_len) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [63:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_KEY_LOW:  key_lo_m  = v;
            CFG_KEY_HIGH: key_hi_m  = v;
            CFG_SHUF_EN:  shuf_en_m = v[0];
            CFG_XOR_EN:   xor_en_m  = v[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic random_blob(int len);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) read_byte(12'($urandom));
            load_byte(8'($urandom), i == len - 1);
        end
        repeat ($urandom_range(3, 12)) begin
            if ($urandom_range(0, 4) == 0) read_byte(12'($urandom));
            else read_byte(12'($urandom_range(0, len)));
        end
    endtask

    task automatic test_directed();
        logic [7:0] ext [17] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hAA, 8'h55, 8'h00,
                                 8'hFF, 8'h10, 8'hEF, 8'h02, 8'hFD, 8'h40, 8'hBF, 8'h20, 8'hDF};
        // reads before any blob completes
        read_byte(12'd0);
        read_byte(12'hFFF);
        // one-byte blob: no swaps
        load_byte(8'hFF, 1'b1);
        read_byte(12'd0);
        read_byte(12'd1);
        // two-byte blob
        load_byte(8'h00, 1'b0);
        read_byte(12'd0);
        load_byte(8'hA5, 1'b1);
        read_byte(12'd0);
        read_byte(12'd1);
        read_byte(12'd2);
        for (int i = 0; i < 17; i++) load_byte(ext[i], i == 16);
        read_byte(12'd0);
        read_byte(12'd15);
        read_byte(12'd16);
        read_byte(12'd17);
        read_byte(12'hFFF);
    endtask

    task automatic test_config_sweep();
        logic [63:0] keys [3] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF};
        for (int s = 0; s < 8; s++) begin
            wait_idle();
            write_reg(CFG_KEY_LOW, (s < 3) ? keys[s] : {$urandom, $urandom});
            write_reg(CFG_KEY_HIGH, (s < 3) ? keys[2 - s] : {$urandom, $urandom});
            write_reg(CFG_SHUF_EN, 64'(s[0]));
            write_reg(CFG_XOR_EN, 64'(s[1]));
            random_blob($urandom_range(1, 24));
            random_blob(1);
        end
        wait_idle();
        write_reg(CFG_SHUF_EN, 64'd1);
        write_reg(CFG_XOR_EN, 64'd1);
    endtask

    task automatic test_overflow();
        no_idle = 1'b1;
        for (int i = 0; i < DEPTH + 4; i++) load_byte(8'($urandom), i == DEPTH + 3);
        no_idle = 1'b0;
        read_byte(12'd0);
        read_byte(12'd100);
        read_byte(12'hFFF);
        // next blob clears the overflow mark
        random_blob(3);
    endtask

    task automatic test_random();
        int start;
        bit paused;
        start  = words_sent;
        paused = 1'b0;
        while (words_sent - start < 1500) begin
            no_idle = ($urandom_range(0, 5) == 0);
            random_blob(($urandom_range(0, 9) == 0) ? $urandom_range(33, 200)
                                                   : $urandom_range(1, 32));
            if (!paused && words_sent - start > 700) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending_reads.size() != 0) @(posedge aclk);
                paused = 1'b1;
            end
        end
        no_idle = 1'b0;
    endtask

    // result checker
    always @(posedge aclk) begin
        rd_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reads.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", m_tdata);
            end else begin
                e = pending_reads.pop_front();
                if (m_tdata[7:0] !== e.out_byte || m_tdata[8] !== e.index_valid
                        || m_tdata[9] !== e.overflow_flag) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("read result: expected byte %h valid %b ovf %b, got %h %b %b",
                                 e.out_byte, e.index_valid, e.overflow_flag,
                                 m_tdata[7:0], m_tdata[8], m_tdata[9]);
                end
            end
        end
    end

    // receiver stalls: mostly short, a few long
    always @(posedge aclk) begin
        if (hold > 0) begin
            hold     <= hold - 1;
            m_tready <= 1'b0;
        end else begin
            rr = $urandom_range(0, 99);
            if (no_idle || rr >= 25) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                hold     <= (rr < 3) ? $urandom_range(10, 40) : $urandom_range(0, 2);
            end
        end
    end

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        s_tlast    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        no_idle    = 1'b0;
        mismatches = 0;
        words_sent = 0;
        key_lo_m   = 64'd6868074465101826641;
        key_hi_m   = 64'd3761121631713969483;
        shuf_en_m  = 1'b1;
        xor_en_m   = 1'b1;
        blob_len   = 0;
        blob_done  = 1'b0;
        ovf_seen   = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_config_sweep();
        test_overflow();
        test_random();

        s_tvalid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0) begin
            $display("keyed_unshuffle_xor_descrambler_top: match");
        end else begin
            $display("keyed_unshuffle_xor_descrambler_top: mismatch");
        end
        $finish;
    end

endmodule
